// ----- hw/rtl/wpc_pkg.sv -----
// ----------------------------------------------------------------------------
// wpc_pkg
// Shared types, constants and tables of the waypoint proportional controller.
// ----------------------------------------------------------------------------
`default_nettype none

package wpc_pkg;

  localparam int unsigned GAIN_FRAC_BITS  = 8;
  localparam int unsigned ANGLE_FRAC_BITS = 13;
  localparam int unsigned CORDIC_STEPS    = 16;
  localparam int unsigned SQRT_STEPS      = 33;

  localparam logic signed [18:0] PI_Q13     = 19'sd25736;
  localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;
  localparam logic signed [20:0] PI_Q16     = 21'sd205887;

  localparam logic KIND_WAYPOINT = 1'b0;
  localparam logic KIND_POSE     = 1'b1;

  typedef enum logic [1:0] {
    CFG_KP_DISTANCE = 2'd0,
    CFG_KP_ANGLE    = 2'd1,
    CFG_EPSILON     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_WAIT
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ_A,
    B_SQ_B,
    B_ROOT,
    B_SCALE,
    B_EMIT
  } back_state_e;

  typedef enum logic [2:0] {
    C_NORM,
    C_TURN,
    C_ROT,
    C_WRAP,
    C_DONE
  } cordic_phase_e;

  // One pose job handed from the front to the back.
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [15:0] heading;
  } job_t;

  // Completion report from the back to the front.
  typedef struct packed {
    logic done;
    logic pop;
  } back_fb_t;

  // Arctangent of 2^-i in units of 2^-16 rad.
  function automatic logic [15:0] atan_lut(input logic [3:0] idx);
    logic [15:0] val;
    case (idx)
      4'd0:    val = 16'd51472;
      4'd1:    val = 16'd30386;
      4'd2:    val = 16'd16055;
      4'd3:    val = 16'd8150;
      4'd4:    val = 16'd4091;
      4'd5:    val = 16'd2047;
      4'd6:    val = 16'd1024;
      4'd7:    val = 16'd512;
      4'd8:    val = 16'd256;
      4'd9:    val = 16'd128;
      4'd10:   val = 16'd64;
      4'd11:   val = 16'd32;
      4'd12:   val = 16'd16;
      4'd13:   val = 16'd8;
      4'd14:   val = 16'd4;
      default: val = 16'd2;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wpc_if.sv -----
// ----------------------------------------------------------------------------
// wpc_if
// Valid/ready channels of the waypoint proportional controller.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpc_item_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [15:0] heading;
  modport source(output valid, kind, x_coord, y_coord, heading, input ready);
  modport sink(input valid, kind, x_coord, y_coord, heading, output ready);
endinterface

interface wpc_result_if;
  logic               valid;
  logic               ready;
  logic        [30:0] linear_speed;
  logic signed [31:0] angular_rate;
  modport source(output valid, linear_speed, angular_rate, input ready);
  modport sink(input valid, linear_speed, angular_rate, output ready);
endinterface

interface wpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wpc_front.sv -----
// ----------------------------------------------------------------------------
// wpc_front
// Accepts items, keeps the waypoint queue and issues pose jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module wpc_front
  import wpc_pkg::*;
#(
  parameter int unsigned QueueDepth = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  wpc_item_if.sink  item,
  output logic      job_valid_o,
  output job_t      job_o,
  input  wire       job_ready_i,
  input  back_fb_t  fb_i
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned SumW = IdxW + 1;

  front_state_e state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic signed [31:0] px_q, py_q, rdx_q, rdy_q;
  logic signed [15:0] hd_q;
  logic [31:0] mem_x [QueueDepth];
  logic [31:0] mem_y [QueueDepth];

  logic            accept;
  logic            full;
  logic [SumW-1:0] tail_sum;
  logic [IdxW-1:0] tail;
  logic [IdxW-1:0] head_inc;

  assign item.ready = (state_q == F_IDLE);
  assign accept     = item.valid && item.ready;
  assign full       = (count_q == CntW'(QueueDepth));
  assign tail_sum   = SumW'(head_q) + SumW'(count_q);
  assign tail       = (tail_sum >= SumW'(QueueDepth)) ?
                      IdxW'(tail_sum - SumW'(QueueDepth)) : IdxW'(tail_sum);
  assign head_inc   = (head_q == IdxW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (accept && item.kind == KIND_WAYPOINT && !full) begin
      mem_x[tail] <= item.x_coord;
      mem_y[tail] <= item.y_coord;
    end
    if (accept) begin
      rdx_q <= mem_x[head_q];
      rdy_q <= mem_y[head_q];
      px_q  <= item.x_coord;
      py_q  <= item.y_coord;
      hd_q  <= item.heading;
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    job_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (accept && item.kind == KIND_WAYPOINT && !full) begin
          count_d = count_q + 1'b1;
        end else if (accept && item.kind == KIND_POSE && count_q != '0) begin
          state_d = F_READ;
        end
      end
      F_READ: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = F_WAIT;
        end
      end
      F_WAIT: begin
        if (fb_i.done) begin
          state_d = F_IDLE;
          if (fb_i.pop) begin
            head_d  = head_inc;
            count_d = count_q - 1'b1;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign job_o.dx      = 33'(rdx_q) - 33'(px_q);
  assign job_o.dy      = 33'(rdy_q) - 33'(py_q);
  assign job_o.heading = hd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("waypoint count beyond queue depth");

  a_fb_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_i.done |-> state_q == F_WAIT)
    else $error("back completion without a job in flight");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item.kind == KIND_WAYPOINT && full) |=> $stable(count_q))
    else $error("dropped waypoint changed the count");

  a_empty_pose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item.kind == KIND_POSE && count_q == '0) |=> state_q == F_IDLE)
    else $error("pose on empty queue started a job");

endmodule

`default_nettype wire

// ----- hw/rtl/wpc_job_fifo.sv -----
// ----------------------------------------------------------------------------
// wpc_job_fifo
// Two-entry queue of pose jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wpc_job_fifo
  import wpc_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_valid_i,
  input  job_t  push_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output job_t  pop_o,
  input  wire   pop_ready_i
);

  job_t       entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_o        = entry_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/wpc_back.sv -----
// ----------------------------------------------------------------------------
// wpc_back
// Distance and bearing engine: squares, square root, CORDIC and gains.
// ----------------------------------------------------------------------------
`default_nettype none

module wpc_back
  import wpc_pkg::*;
#(
  parameter int PosFracBits = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  wpc_cfg_if.sink      cfg,
  input  wire          job_valid_i,
  input  job_t         job_i,
  output logic         job_ready_o,
  output back_fb_t     fb_o,
  wpc_result_if.source res
);

  localparam int RateShift = PosFracBits - int'(GAIN_FRAC_BITS) - int'(ANGLE_FRAC_BITS);
  localparam int LShift    = (RateShift >= 0) ? RateShift : 0;
  localparam int RShift    = (RateShift < 0) ? -RateShift : 0;

  // Configuration registers.
  logic [15:0] kp_dist_q, kp_ang_q;
  logic [30:0] eps_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_dist_q <= 16'd128;
      kp_ang_q  <= 16'd256;
      eps_q     <= 31'd3277;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_KP_DISTANCE: kp_dist_q <= cfg.data[15:0];
        CFG_KP_ANGLE:    kp_ang_q  <= cfg.data[15:0];
        CFG_EPSILON:     eps_q     <= cfg.data[30:0];
        default:         ;
      endcase
    end
  end

  back_state_e state_q, state_d;
  logic        load;

  // Magnitude path.
  logic [32:0] ax_q, ay_q;
  logic [65:0] sq_q, rad_q, prod;
  logic [36:0] rem_q, rem_n, trial;
  logic [33:0] root_q;
  logic [5:0]  sq_cnt_q;
  logic        sq_done;

  // Bearing path.
  cordic_phase_e      cph_q;
  logic signed [44:0] cx_q, cy_q, xs, ys, amx, amy, mag;
  logic signed [20:0] cz_q;
  logic [3:0]         ci_q;
  logic signed [15:0] hd_q;
  logic signed [18:0] err_q, bear, err_a, err_b;

  // Gain products and output register.
  logic [49:0]        spd_q;
  logic signed [35:0] rte_q;
  logic [41:0]        spd_sh;
  logic signed [39:0] rte_sh;
  logic [30:0]        speed;
  logic signed [31:0] rate;
  logic               out_valid_q, out_load;
  logic [30:0]        out_speed_q;
  logic signed [31:0] out_rate_q;

  assign job_ready_o = (state_q == B_IDLE);
  assign load        = job_valid_i && job_ready_o;
  assign prod        = (state_q == B_SQ_A) ? 66'(ax_q * ax_q) : 66'(ay_q * ay_q);
  assign sq_done     = (sq_cnt_q == 6'(SQRT_STEPS));
  assign rem_n       = {rem_q[34:0], rad_q[65:64]};
  assign trial       = {1'b0, root_q, 2'b01};

  assign amx = cx_q[44] ? -cx_q : cx_q;
  assign amy = cy_q[44] ? -cy_q : cy_q;
  assign mag = (amx > amy) ? amx : amy;
  assign xs  = cx_q >>> ci_q;
  assign ys  = cy_q >>> ci_q;

  always_comb begin
    bear  = 19'((cz_q + 21'sd4) >>> 3);
    err_a = bear - 19'(hd_q);
    if (err_a > PI_Q13) err_a = err_a - TWO_PI_Q13;
    err_b = err_a;
    if (err_b < -PI_Q13) err_b = err_b + TWO_PI_Q13;
  end

  always_comb begin
    spd_sh = 42'(spd_q >> GAIN_FRAC_BITS);
    speed  = (spd_sh > 42'h7FFF_FFFF) ? 31'h7FFF_FFFF : spd_sh[30:0];
    rte_sh = (40'(rte_q) <<< LShift) >>> RShift;
    if (rte_sh > 40'sh00_7FFF_FFFF) begin
      rate = 32'sh7FFF_FFFF;
    end else if (rte_sh < -40'sh00_8000_0000) begin
      rate = -32'sh8000_0000;
    end else begin
      rate = rte_sh[31:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    fb_o     = '0;
    out_load = 1'b0;
    unique case (state_q)
      B_IDLE:  if (load) state_d = B_SQ_A;
      B_SQ_A:  state_d = B_SQ_B;
      B_SQ_B:  state_d = B_ROOT;
      B_ROOT: begin
        if (sq_done && cph_q == C_DONE) begin
          if (root_q <= 34'(eps_q)) begin
            fb_o    = '{done: 1'b1, pop: 1'b1};
            state_d = B_IDLE;
          end else begin
            state_d = B_SCALE;
          end
        end
      end
      B_SCALE: state_d = B_EMIT;
      B_EMIT: begin
        if (!out_valid_q || res.ready) begin
          out_load = 1'b1;
          fb_o     = '{done: 1'b1, pop: 1'b0};
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ax_q <= job_i.dx[32] ? 33'(-job_i.dx) : 33'(job_i.dx);
      ay_q <= job_i.dy[32] ? 33'(-job_i.dy) : 33'(job_i.dy);
      cx_q <= 45'(job_i.dx);
      cy_q <= 45'(job_i.dy);
      cz_q <= '0;
      hd_q <= job_i.heading;
    end else begin
      unique case (cph_q)
        C_NORM: begin
          if (mag != '0 && mag[44:40] == '0) begin
            if (mag[44:32] == '0) begin
              cx_q <= cx_q <<< 8;
              cy_q <= cy_q <<< 8;
            end else begin
              cx_q <= cx_q <<< 1;
              cy_q <= cy_q <<< 1;
            end
          end
        end
        C_TURN: begin
          if (cx_q[44]) begin
            cz_q <= cy_q[44] ? -PI_Q16 : PI_Q16;
            cx_q <= -cx_q;
            cy_q <= -cy_q;
          end
        end
        C_ROT: begin
          if (!cy_q[44]) begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            cz_q <= cz_q + 21'(atan_lut(ci_q));
          end else begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            cz_q <= cz_q - 21'(atan_lut(ci_q));
          end
        end
        C_WRAP:  err_q <= err_b;
        default: ;
      endcase
    end
    if (state_q == B_SQ_A) sq_q <= prod;
    if (state_q == B_SQ_B) begin
      rad_q  <= sq_q + prod;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == B_ROOT && !sq_done) begin
      rad_q <= rad_q << 2;
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[32:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[32:0], 1'b0};
      end
    end
    if (state_q == B_SCALE) begin
      spd_q <= 50'(kp_dist_q * root_q);
      rte_q <= 36'($signed({1'b0, kp_ang_q}) * err_q);
    end
    if (out_load) begin
      out_speed_q <= speed;
      out_rate_q  <= rate;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cph_q       <= C_DONE;
      ci_q        <= '0;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        cph_q <= C_NORM;
        ci_q  <= '0;
      end else begin
        case (cph_q)
          C_NORM: if (mag == '0 || mag[44:40] != '0) cph_q <= C_TURN;
          C_TURN: cph_q <= C_ROT;
          C_ROT: begin
            ci_q <= ci_q + 4'd1;
            if (ci_q == 4'(CORDIC_STEPS - 1)) cph_q <= C_WRAP;
          end
          C_WRAP:  cph_q <= C_DONE;
          default: cph_q <= C_DONE;
        endcase
      end
      if (state_q == B_SQ_B) begin
        sq_cnt_q <= '0;
      end else if (state_q == B_ROOT && !sq_done) begin
        sq_cnt_q <= sq_cnt_q + 6'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res.valid        = out_valid_q;
  assign res.linear_speed = out_speed_q;
  assign res.angular_rate = out_rate_q;

  a_fb_from_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_o.done |-> (state_q == B_ROOT || state_q == B_EMIT))
    else $error("completion outside root or emit");

  a_pop_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fb_o.done && fb_o.pop) |=> !$rose(out_valid_q))
    else $error("arrival produced a result");

  a_root_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_ROOT && state_d != B_ROOT) |-> (sq_done && cph_q == C_DONE))
    else $error("left root stage before both units finished");

endmodule

`default_nettype wire

// ----- hw/rtl/waypoint_proportional_controller.sv -----
// ----------------------------------------------------------------------------
// waypoint_proportional_controller
// Go-to-goal proportional controller with a waypoint queue.
// ----------------------------------------------------------------------------
// A waypoint item (kind 0) appends a target, or is dropped when the queue
// is full. A pose item (kind 1) on an empty queue does nothing. Otherwise
// the front reads the head target and hands the offsets to the back, which
// works out the distance and the bearing error; the next item is taken only
// once the back has finished with it. A pose item passes through squaring
// of each offset on a shared multiplier, a one-bit-a-step square root beside
// the CORDIC bearing unit (scaling, turn, rotation and wrap phases), a gain
// step and an emit step. When the distance does not exceed epsilon the head
// target is popped and no result leaves; otherwise one result carries the
// saturated linear speed and angular rate. Results sit in an output register,
// so one held result does not stop waypoint items; a further result waits in
// the emit step and no item is taken meanwhile. The user writes gains and
// epsilon on the config channel (index 0 kp_distance, 1 kp_angle, 2 epsilon)
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_proportional_controller
  import wpc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH        = 16,
  parameter int          POSITION_FRAC_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  wpc_cfg_if.sink      cfg_i,
  wpc_item_if.sink     item_i,
  wpc_result_if.source result_o
);

  // Pose jobs travel from the front through a short queue to the back.
  logic     fe_job_valid, fe_job_ready;
  job_t     fe_job;
  logic     be_job_valid, be_job_ready;
  job_t     be_job;
  back_fb_t back_fb;

  wpc_front #(
    .QueueDepth(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item        (item_i),
    .job_valid_o (fe_job_valid),
    .job_o       (fe_job),
    .job_ready_i (fe_job_ready),
    .fb_i        (back_fb)
  );

  wpc_job_fifo u_job_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_job_valid),
    .push_i       (fe_job),
    .push_ready_o (fe_job_ready),
    .pop_valid_o  (be_job_valid),
    .pop_o        (be_job),
    .pop_ready_i  (be_job_ready)
  );

  wpc_back #(
    .PosFracBits(POSITION_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg         (cfg_i),
    .job_valid_i (be_job_valid),
    .job_i       (be_job),
    .job_ready_o (be_job_ready),
    .fb_o        (back_fb),
    .res         (result_o)
  );

endmodule

`default_nettype wire
